### src/sfw_pkg.sv
package sfw_pkg;

   // Default sizes of the bin store
   localparam int MAX_BINS_DEF   = 2048;
   localparam int VALUE_BITS_DEF = 32;

   // Field widths of the request and response items
   localparam int INDEX_W    = 11;
   localparam int VAL_W      = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 48;
   localparam int PAD_W      = RSP_DATA_W - INDEX_W - VAL_W;

   // Configuration register widths
   localparam int RATIO_W    = 18;
   localparam int WIDTH_W    = 12;
   localparam int CSR_DATA_W = 18;
   localparam int CSR_ADDR_W = 1;

   // Fixed-point position format
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 13;
   localparam logic [RATIO_W-1:0]     RATIO_ONE = RATIO_W'(65536);
   localparam logic [FRAC_BITS:0]     WEIGHT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // Reset values of the configuration registers
   localparam logic [RATIO_W-1:0] RATIO_RST  = RATIO_ONE;
   localparam logic [WIDTH_W-1:0] ACTIVE_RST = WIDTH_W'(1025);

   // Request kinds carried on tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Response status carried on tuser
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WARP_RATIO  = 1'b0,
      CSR_ACTIVE_BINS = 1'b1
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_POS,
      S_ADDR_A,
      S_ADDR_B,
      S_TAP_B,
      S_DONE,
      S_RESP
   } sfw_state_type;

   // Control of the shared multiply-accumulate unit
   typedef struct packed {
      logic en;
      logic acc;
   } mac_ctl_type;

endpackage

### src/sfw_ram.sv
module sfw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/sfw_mac.sv
module sfw_mac #(
   parameter int A_W = 32,
   parameter int B_W = 17
) (
   input  logic                  clock,
   input  sfw_pkg::mac_ctl_type  ctl,
   input  logic [A_W-1:0]        op_a,
   input  logic [B_W-1:0]        op_b,
   output logic [A_W+B_W:0]      acc
);
   import sfw_pkg::*;

   localparam int ACC_W = A_W + B_W + 1;

   logic [A_W+B_W-1:0] prod;
   logic [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]   acc_in;

   // Multiply, then either start a new sum or add to the running one
   always_comb begin
      prod   = op_a * op_b;
      acc_in = (ctl.acc ? acc_ff : '0) + ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (ctl.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

### src/spectral_frequency_warp.sv
// Frequency warp of one spectral-envelope frame.
// Request channel (req_*): tuser 0 stores bin_value at bin_index, tuser 1 asks
// for warped output bin bin_index. Only reads produce a response.
// Response channel (rsp_*): echoed index, interpolated value and a status flag
// that is set, with a zero value, when the index is at or past the active width.
// Configuration (csr_*): index 0 is the Q2.16 warp ratio, index 1 the number of
// active bins; write only while no read is in flight.
// Sequencing: a write is stored and the block stays ready for a new request.
// An in-range read steps through S_POS, S_ADDR_A, S_ADDR_B, S_TAP_B and S_DONE
// before its response is shown in S_RESP; an out-of-range read goes straight
// to S_RESP. The next request is taken the cycle after the response is taken.
// A read is sequenced because one shared multiply-accumulate unit is used three
// times per read and the single read port of the bin memory twice.
// While a response waits on rsp_tready the block holds it and takes no request.
// Reset sets the ratio to 1.0 and the width to 1025 bins; bin contents are
// undefined until written and are not cleared.
module spectral_frequency_warp #(
   parameter int MAX_BINS   = sfw_pkg::MAX_BINS_DEF,
   parameter int VALUE_BITS = sfw_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sfw_pkg::REQ_DATA_W-1:0]   req_tdata,  // bin_index[10:0], bin_value[42:11]
   input  logic                             req_tuser,  // op[0]
   // Response channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sfw_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // out_index[10:0], out_value[42:11]
   output logic                             rsp_tuser,  // status[0]
   // Configuration port
   input  logic                             csr_we,
   input  logic [sfw_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [sfw_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import sfw_pkg::*;

   localparam int ADDR_W = $clog2(MAX_BINS);
   localparam int CMP_W  = (ADDR_W + 1 > POS_W) ? ADDR_W + 1 : POS_W;
   localparam int A_W    = (VALUE_BITS > RATIO_W) ? VALUE_BITS : RATIO_W;
   localparam int B_W    = FRAC_BITS + 1;
   localparam int ACC_W  = A_W + B_W + 1;

   sfw_state_type state_ff, state_in;

   logic [RATIO_W-1:0]   ratio_ff, ratio_in;
   logic [WIDTH_W-1:0]   active_ff, active_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]    last_ff, last_in;
   logic [ADDR_W-1:0]    i1_ff, i1_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic [VAL_W-1:0]     res_ff, res_in;
   logic                 status_ff, status_in;

   logic [INDEX_W-1:0]    req_index;
   logic [VAL_W-1:0]      req_value;
   logic [CMP_W-1:0]      width_eff;
   logic                  passthru;
   logic [POS_W-1:0]      pos_int;
   logic [FRAC_BITS-1:0]  pos_frac;
   logic [ADDR_W-1:0]     i2;

   logic                  ram_we;
   logic [ADDR_W-1:0]     ram_waddr;
   logic [VALUE_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]     ram_raddr;
   logic [VALUE_BITS-1:0] ram_rdata;

   mac_ctl_type           mac_ctl;
   logic [A_W-1:0]        mac_a;
   logic [B_W-1:0]        mac_b;
   logic [ACC_W-1:0]      mac_q;

   sfw_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_BINS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sfw_mac #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_q)
   );

   // Unpack the request and derive the working width
   assign req_index = req_tdata[INDEX_W-1:0];
   assign req_value = req_tdata[INDEX_W +: VAL_W];
   assign width_eff = (CMP_W'(active_ff) > CMP_W'(MAX_BINS)) ? CMP_W'(MAX_BINS)
                                                               : CMP_W'(active_ff);
   assign passthru  = (ratio_ff == '0) || (ratio_ff == RATIO_ONE);

   // Split the position product into source bin and fraction
   assign pos_int  = mac_q[FRAC_BITS +: POS_W];
   assign pos_frac = mac_q[FRAC_BITS-1:0];
   assign i2       = (i1_ff == last_ff) ? last_ff : i1_ff + 1'b1;

   // Handshake and response payload
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {{PAD_W{1'b0}}, res_ff, idx_ff};
   assign rsp_tuser  = status_ff;

   // Sequence one request through the shared unit
   always_comb begin
      state_in  = state_ff;
      ratio_in  = ratio_ff;
      active_in = active_ff;
      idx_in    = idx_ff;
      last_in   = last_ff;
      i1_in     = i1_ff;
      frac_in   = frac_ff;
      res_in    = res_ff;
      status_in = status_ff;

      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(req_index);
      ram_wdata = VALUE_BITS'(req_value);
      ram_raddr = i1_ff;

      mac_ctl   = '0;
      mac_a     = '0;
      mac_b     = '0;

      // Take configuration writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_WARP_RATIO:  ratio_in  = csr_wdata[RATIO_W-1:0];
            CSR_ACTIVE_BINS: active_in = csr_wdata[WIDTH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_WRITE) begin
                  // Store the bin; drop writes past the store
                  ram_we = (CMP_W'(req_index) < CMP_W'(MAX_BINS));
               end else begin
                  idx_in  = req_index;
                  last_in = ADDR_W'(width_eff - 1'b1);
                  if (CMP_W'(req_index) >= width_eff) begin
                     res_in    = '0;
                     status_in = STATUS_RANGE;
                     state_in  = S_RESP;
                  end else begin
                     status_in = STATUS_OK;
                     state_in  = S_POS;
                  end
               end
            end
         end
         S_POS: begin
            // Form the source position; passthrough uses a ratio of one
            mac_ctl.en = 1'b1;
            mac_a      = A_W'(passthru ? RATIO_ONE : ratio_ff);
            mac_b      = B_W'(idx_ff);
            state_in   = S_ADDR_A;
         end
         S_ADDR_A: begin
            // Clamp the lower source bin and fetch it
            i1_in     = (CMP_W'(pos_int) > CMP_W'(last_ff)) ? last_ff : ADDR_W'(pos_int);
            frac_in   = pos_frac;
            ram_raddr = i1_in;
            state_in  = S_ADDR_B;
         end
         S_ADDR_B: begin
            // Weight the lower bin and fetch the upper one
            ram_raddr  = i2;
            mac_ctl.en = 1'b1;
            mac_a      = A_W'(ram_rdata);
            mac_b      = WEIGHT_ONE - B_W'(frac_ff);
            state_in   = S_TAP_B;
         end
         S_TAP_B: begin
            // Add the weighted upper bin; a zero weight takes no data
            mac_ctl.en  = 1'b1;
            mac_ctl.acc = 1'b1;
            mac_a       = (frac_ff == '0) ? '0 : A_W'(ram_rdata);
            mac_b       = B_W'(frac_ff);
            state_in    = S_DONE;
         end
         S_DONE: begin
            res_in   = VAL_W'(mac_q >> FRAC_BITS);
            state_in = S_RESP;
         end
         S_RESP: begin
            // Hold the response until it is taken
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ratio_ff  <= RATIO_RST;
         active_ff <= ACTIVE_RST;
      end else begin
         state_ff  <= state_in;
         ratio_ff  <= ratio_in;
         active_ff <= active_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      last_ff   <= last_in;
      i1_ff     <= i1_in;
      frac_ff   <= frac_in;
      res_ff    <= res_in;
      status_ff <= status_in;
   end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sfw_pkg::*;

   typedef enum logic {ROW_REQUEST, ROW_CSR} row_kind_type;

   // One line of the directed table; csr rows carry the register value in value
   typedef struct {
      row_kind_type       kind;
      logic               op;
      csr_index_type      csr_index;
      logic [INDEX_W-1:0] index;
      logic [VAL_W-1:0]   value;
      bit                 typed;
      logic [VAL_W-1:0]   exp_value;
      logic               exp_status;
   } stim_row_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [VAL_W-1:0]   value;
      logic               status;
   } warp_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // bin_index[10:0], bin_value[42:11]
   logic                  req_tuser;  // op[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // out_index[10:0], out_value[42:11]
   logic                  rsp_tuser;  // status[0]
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow of the frame and of the registers
   logic [VAL_W-1:0]   frame_bins [MAX_BINS_DEF];
   bit                 bin_written [MAX_BINS_DEF];
   logic [RATIO_W-1:0] ratio_q;
   logic [WIDTH_W-1:0] width_q;

   warp_result_type warped_due[$];
   stim_row_type    directed_rows[$];

   int send_idle_pct;
   int sink_idle_pct;
   int error_count;
   int stores_done;
   int reads_done;
   int range_reads;
   int settings_done;

   spectral_frequency_warp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #(5_000_000);
      $display("Verification failed");
      $finish;
   end

   function automatic logic [12:0] active_span();
      return (width_q > WIDTH_W'(MAX_BINS_DEF)) ? 13'(MAX_BINS_DEF) : 13'(width_q);
   endfunction

   // Work out the two source bins and the fraction; return 0 when out of range
   function automatic bit read_taps(input logic [INDEX_W-1:0] index,
                                    output logic [12:0] tap_a,
                                    output logic [12:0] tap_b,
                                    output logic [FRAC_BITS-1:0] frac);
      logic [12:0] span;
      logic [12:0] last;
      logic [31:0] pos;
      span  = active_span();
      tap_a = 13'(index);
      tap_b = 13'(index);
      frac  = '0;
      if (13'(index) >= span)
         return 1'b0;
      last = span - 13'd1;
      if (ratio_q != '0 && ratio_q != RATIO_ONE) begin
         pos   = 32'(index) * 32'(ratio_q);
         frac  = pos[FRAC_BITS-1:0];
         tap_a = (pos[31:16] > 16'(last)) ? last : pos[28:16];
         tap_b = (tap_a + 13'd1 > last) ? last : tap_a + 13'd1;
      end
      return 1'b1;
   endfunction

   // Expected response of one warped read against the current frame
   function automatic warp_result_type warp_lookup(input logic [INDEX_W-1:0] index);
      warp_result_type      r;
      logic [12:0]          tap_a;
      logic [12:0]          tap_b;
      logic [FRAC_BITS-1:0] frac;
      logic [63:0]          mix;
      r.index = index;
      if (!read_taps(index, tap_a, tap_b, frac)) begin
         r.value  = '0;
         r.status = STATUS_RANGE;
      end else begin
         mix = 64'(frame_bins[tap_a]) * (64'(WEIGHT_ONE) - 64'(frac))
             + 64'(frame_bins[tap_b]) * 64'(frac);
         r.value  = mix[47:16];
         r.status = STATUS_OK;
      end
      return r;
   endfunction

   function automatic stim_row_type store_row(input logic [INDEX_W-1:0] index,
                                              input logic [VAL_W-1:0] value);
      stim_row_type r;
      r = '{ROW_REQUEST, OP_WRITE, CSR_WARP_RATIO, index, value, 1'b0, '0, STATUS_OK};
      return r;
   endfunction

   function automatic stim_row_type read_row(input logic [INDEX_W-1:0] index,
                                             input bit typed,
                                             input logic [VAL_W-1:0] exp_value,
                                             input logic exp_status);
      stim_row_type r;
      r = '{ROW_REQUEST, OP_READ, CSR_WARP_RATIO, index, '0, typed, exp_value, exp_status};
      return r;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type which,
                                            input logic [VAL_W-1:0] value);
      stim_row_type r;
      r = '{ROW_CSR, OP_WRITE, which, '0, value, 1'b0, '0, STATUS_OK};
      return r;
   endfunction

   // Append one line to the directed table
   function automatic void add_row(input stim_row_type r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Present one request, idling first at random, and hold it until taken
   task automatic offer(input logic op, input logic [INDEX_W-1:0] index,
                        input logic [VAL_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_DATA_W'({value, index});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic store_bin(input logic [INDEX_W-1:0] index, input logic [VAL_W-1:0] value);
      offer(OP_WRITE, index, value);
      frame_bins[index]  = value;
      bin_written[index] = 1'b1;
      stores_done++;
   endtask

   // Fill any source bin that was never stored, then issue the read
   task automatic request_read(input logic [INDEX_W-1:0] index, input bit typed,
                               input logic [VAL_W-1:0] exp_value, input logic exp_status);
      logic [12:0]          tap_a;
      logic [12:0]          tap_b;
      logic [FRAC_BITS-1:0] frac;
      warp_result_type      due;
      if (read_taps(index, tap_a, tap_b, frac)) begin
         if (!bin_written[tap_a])
            store_bin(tap_a[INDEX_W-1:0], $urandom());
         if (!bin_written[tap_b])
            store_bin(tap_b[INDEX_W-1:0], $urandom());
      end
      offer(OP_READ, index, $urandom());
      if (typed) begin
         due.index  = index;
         due.value  = exp_value;
         due.status = exp_status;
      end else begin
         due = warp_lookup(index);
      end
      if (due.status == STATUS_RANGE)
         range_reads++;
      reads_done++;
      warped_due.insert(warped_due.size(), due);
   endtask

   // Drop valid and wait until every response is back and the block is quiet
   task automatic settle_frame();
      req_tvalid <= 1'b0;
      while (warped_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type which, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= which;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (which == CSR_WARP_RATIO)
         ratio_q = data[RATIO_W-1:0];
      else
         width_q = data[WIDTH_W-1:0];
      settings_done++;
   endtask

   // Response side: check each taken response, then pick the next ready
   initial begin
      warp_result_type want;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (warped_due.size() == 0) begin
               flag_error($sformatf("response index %0d value %h status %0d with none due",
                                    rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W +: VAL_W],
                                    rsp_tuser));
            end else begin
               want = warped_due.pop_front();
               if (rsp_tdata[INDEX_W-1:0] !== want.index
                   || rsp_tdata[INDEX_W +: VAL_W] !== want.value
                   || rsp_tuser !== want.status)
                  flag_error($sformatf({"expected index %0d value %h status %0d, ",
                                        "got index %0d value %h status %0d"},
                                       want.index, want.value, want.status,
                                       rsp_tdata[INDEX_W-1:0], rsp_tdata[INDEX_W +: VAL_W],
                                       rsp_tuser));
            end
         end
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   initial begin
      stim_row_type          row;
      int                    send_pct_by_mode[3];
      int                    sink_pct_by_mode[3];
      logic [RATIO_W-1:0]    ratio_pick;
      logic [WIDTH_W-1:0]    width_pick;
      logic [12:0]           span;
      logic [INDEX_W-1:0]    index;
      logic [VAL_W-1:0]      value;
      int                    pick;

      send_pct_by_mode = '{34, 81, 0};
      sink_pct_by_mode = '{81, 34, 0};
      error_count   = 0;
      stores_done   = 0;
      reads_done    = 0;
      range_reads   = 0;
      settings_done = 0;
      send_idle_pct = send_pct_by_mode[0];
      sink_idle_pct = sink_pct_by_mode[0];
      ratio_q = RATIO_RST;
      width_q = ACTIVE_RST;
      foreach (bin_written[k])
         bin_written[k] = 1'b0;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_WRITE;
      csr_we     <= 1'b0;
      csr_addr   <= CSR_WARP_RATIO;
      csr_wdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, passthrough, ratio extremes, clamping, tiny widths
      add_row(store_row(11'd0, 32'hFFFF_FFFF));
      add_row(store_row(11'd1, 32'h0000_0000));
      add_row(store_row(11'd2047, 32'hA5A5_5A5A));
      add_row(store_row(11'd1024, 32'h1234_5678));
      add_row(store_row(11'd1025, 32'h5A5A_A5A5));
      add_row(read_row(11'd0, 1'b1, 32'hFFFF_FFFF, STATUS_OK));
      add_row(read_row(11'd1024, 1'b1, 32'h1234_5678, STATUS_OK));
      add_row(read_row(11'd1025, 1'b1, '0, STATUS_RANGE));
      add_row(read_row(11'd2047, 1'b1, '0, STATUS_RANGE));
      add_row(csr_row(CSR_WARP_RATIO, 32'd0));
      add_row(read_row(11'd1, 1'b1, 32'h0000_0000, STATUS_OK));
      add_row(csr_row(CSR_ACTIVE_BINS, 32'd2048));
      add_row(read_row(11'd2047, 1'b1, 32'hA5A5_5A5A, STATUS_OK));
      add_row(csr_row(CSR_WARP_RATIO, 32'h3FFFF));
      add_row(read_row(11'd2047, 1'b1, 32'hA5A5_5A5A, STATUS_OK));
      add_row(read_row(11'd1, 1'b0, '0, STATUS_OK));
      add_row(csr_row(CSR_WARP_RATIO, 32'd32768));
      add_row(read_row(11'd1, 1'b1, 32'h7FFF_FFFF, STATUS_OK));
      add_row(read_row(11'd2047, 1'b0, '0, STATUS_OK));
      add_row(csr_row(CSR_ACTIVE_BINS, 32'd1));
      add_row(read_row(11'd0, 1'b1, 32'hFFFF_FFFF, STATUS_OK));
      add_row(read_row(11'd1, 1'b1, '0, STATUS_RANGE));
      add_row(csr_row(CSR_ACTIVE_BINS, 32'd0));
      add_row(read_row(11'd0, 1'b1, '0, STATUS_RANGE));
      add_row(csr_row(CSR_ACTIVE_BINS, 32'd4095));
      add_row(read_row(11'd2047, 1'b0, '0, STATUS_OK));
      add_row(csr_row(CSR_WARP_RATIO, 32'd65536));
      add_row(read_row(11'd2047, 1'b1, 32'hA5A5_5A5A, STATUS_OK));

      foreach (directed_rows[k]) begin
         row = directed_rows[k];
         if (row.kind == ROW_CSR) begin
            settle_frame();
            write_csr(row.csr_index, row.value[CSR_DATA_W-1:0]);
         end else if (row.op == OP_WRITE) begin
            store_bin(row.index, row.value);
         end else begin
            request_read(row.index, row.typed, row.exp_value, row.exp_status);
         end
      end

      // Random: three idling modes, four register settings each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = send_pct_by_mode[mode];
         sink_idle_pct = sink_pct_by_mode[mode];
         for (int seg = 0; seg < 4; seg++) begin
            case ($urandom_range(5))
               0: ratio_pick = RATIO_ONE;
               1: ratio_pick = '0;
               2: ratio_pick = '1;
               3: ratio_pick = RATIO_W'(1);
               4: ratio_pick = RATIO_W'($urandom_range(131072, 32768));
               default: ratio_pick = RATIO_W'($urandom());
            endcase
            case ($urandom_range(6))
               0: width_pick = WIDTH_W'(2);
               1: width_pick = WIDTH_W'(MAX_BINS_DEF);
               2: width_pick = WIDTH_W'($urandom_range(2048, 2));
               3: width_pick = WIDTH_W'($urandom_range(64, 2));
               4: width_pick = ACTIVE_RST;
               5: width_pick = WIDTH_W'($urandom_range(300, 16));
               default: begin
                  case ($urandom_range(2))
                     0: width_pick = '0;
                     1: width_pick = WIDTH_W'(1);
                     default: width_pick = '1;
                  endcase
               end
            endcase
            settle_frame();
            write_csr(CSR_WARP_RATIO, CSR_DATA_W'(ratio_pick));
            write_csr(CSR_ACTIVE_BINS, CSR_DATA_W'(width_pick));
            span = active_span();

            for (int n = 0; n < 75; n++) begin
               pick = $urandom_range(99);
               if (pick < 30) begin
                  // Store, mostly inside the active frame
                  case ($urandom_range(3))
                     0: value = '0;
                     1: value = '1;
                     default: value = $urandom();
                  endcase
                  if (span != 0 && $urandom_range(3) != 0)
                     index = INDEX_W'($urandom_range(span - 1));
                  else
                     index = INDEX_W'($urandom());
                  store_bin(index, value);
               end else if (pick < 40 && span < 13'(MAX_BINS_DEF)) begin
                  request_read(INDEX_W'($urandom_range(2047, span)), 1'b0, '0, STATUS_OK);
               end else if (span == 0) begin
                  request_read(INDEX_W'($urandom()), 1'b0, '0, STATUS_OK);
               end else begin
                  // Warped read, leaning on the frame edges
                  case ($urandom_range(4))
                     0: index = INDEX_W'(span - 1);
                     1: index = '0;
                     default: index = INDEX_W'($urandom_range(span - 1));
                  endcase
                  request_read(index, 1'b0, '0, STATUS_OK);
               end
            end
         end
      end

      // Drain the outstanding responses
      req_tvalid <= 1'b0;
      while (warped_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Stored %0d bins and read %0d warped bins, %0d beyond the active width,",
               stores_done, reads_done, range_reads);
      $display("across %0d register writes and three idling modes; %0d mismatches.",
               settings_done, error_count);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
